// ----- rtl/core/bmp_pixel_array_unpack_assert.svh -----
// Assertion macros shared by the BMP pixel array unpacker RTL.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef BMP_PIXEL_ARRAY_UNPACK_ASSERT_SVH
`define BMP_PIXEL_ARRAY_UNPACK_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BMPU_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bmpu assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define BMPU_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bmpu assertion failed");

`endif

// ----- rtl/core/bmpu_pkg.sv -----
// Shared types and constants of the BMP pixel array unpacker.
// No dependencies; used by every module of the block.
package bmpu_pkg;

	localparam int StoreCols = 800;
	localparam int StoreRows = 480;
	localparam int CfgIdxW   = 3;
	localparam int CfgDataW  = 11;

	typedef enum logic [CfgIdxW-1:0] {
		REG_DEPTH_IS_32  = 3'd0,
		REG_IMAGE_WIDTH  = 3'd1,
		REG_IMAGE_HEIGHT = 3'd2,
		REG_STORE_MODE   = 3'd3,
		REG_X_ORIGIN     = 3'd4,
		REG_Y_ORIGIN     = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic               depth_is_32;
		logic [9:0]         image_width;
		logic signed [9:0]  image_height;
		logic               store_mode;
		logic signed [10:0] x_origin;
		logic signed [9:0]  y_origin;
	} cfg_t;

	typedef struct packed {
		logic        last_pixel;
		logic        write_enable;
		logic        to_store;
		logic [8:0]  row;
		logic [9:0]  column;
		logic [31:0] argb;
	} res_t;

endpackage

// ----- rtl/core/bmpu_cfg_regs.sv -----
// Configuration register file of the BMP pixel array unpacker.
// Depends on bmpu_pkg for the register indexes and the cfg_t struct.
module bmpu_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [bmpu_pkg::CfgIdxW-1:0]  wr_index,
	input  logic [bmpu_pkg::CfgDataW-1:0] wr_data,
	output bmpu_pkg::cfg_t                cfg
);

	bmpu_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.depth_is_32  <= 1'b0;
			cfg_q.image_width  <= 10'd800;
			cfg_q.image_height <= 10'sd480;
			cfg_q.store_mode   <= 1'b0;
			cfg_q.x_origin     <= '0;
			cfg_q.y_origin     <= '0;
		end else if (wr_en) begin
			// Indexes past the last register are dropped.
			case (bmpu_pkg::cfg_reg_t'(wr_index))
				bmpu_pkg::REG_DEPTH_IS_32:  cfg_q.depth_is_32  <= wr_data[0];
				bmpu_pkg::REG_IMAGE_WIDTH:  cfg_q.image_width  <= wr_data[9:0];
				bmpu_pkg::REG_IMAGE_HEIGHT: cfg_q.image_height <= wr_data[9:0];
				bmpu_pkg::REG_STORE_MODE:   cfg_q.store_mode   <= wr_data[0];
				bmpu_pkg::REG_X_ORIGIN:     cfg_q.x_origin     <= wr_data[10:0];
				bmpu_pkg::REG_Y_ORIGIN:     cfg_q.y_origin     <= wr_data[9:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/core/bmpu_decode.sv -----
// Byte decoder of the BMP pixel array unpacker: pixel assembly, row and column
// counters, padding skip and destination mapping. Depends on bmpu_pkg.
`include "bmp_pixel_array_unpack_assert.svh"

module bmpu_decode #(
	parameter int SCREEN_WIDTH  = 800,
	parameter int SCREEN_HEIGHT = 480
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  logic [7:0]     pixel_byte,
	input  bmpu_pkg::cfg_t cfg,
	output logic           res_valid,
	output bmpu_pkg::res_t res
);

	logic [1:0]  phase_q;
	logic [23:0] part_q;
	logic [9:0]  col_q;
	logic [8:0]  row_q;
	logic [1:0]  pad_q;
	logic        pad_act_q;

	logic [1:0]  phase_d;
	logic [23:0] part_d;
	logic [9:0]  col_d;
	logic [8:0]  row_d;
	logic [1:0]  pad_d;
	logic        pad_act_d;

	logic [10:0]        w_eff;
	logic               h_pos;
	logic [9:0]         rows;
	logic signed [11:0] col_ext;
	logic signed [11:0] base_row;
	logic signed [11:0] draw_col;
	logic signed [11:0] draw_row;
	logic               store_we;
	logic               draw_we;
	logic               we;
	logic               row_end;
	logic               last;
	logic [23:0]        part_r;

	always_comb begin
		w_eff    = (cfg.image_width == '0) ? 11'd1024 : {1'b0, cfg.image_width};
		h_pos    = !cfg.image_height[9] && (cfg.image_height != '0);
		rows     = cfg.image_height[9] ? 10'(-cfg.image_height) : cfg.image_height;
		col_ext  = {2'b00, col_q};
		// Bottom-up storage flips the row order.
		base_row = h_pos ? (12'(cfg.image_height) - 12'sd1 - {3'b000, row_q})
		                 : {3'b000, row_q};
		draw_col = col_ext + 12'(cfg.x_origin);
		draw_row = base_row + 12'(cfg.y_origin);
		store_we = (32'(col_q) < bmpu_pkg::StoreCols) && !base_row[11]
		           && (32'(base_row[10:0]) < bmpu_pkg::StoreRows);
		draw_we  = h_pos && !draw_col[11] && (32'(draw_col[10:0]) < SCREEN_WIDTH)
		           && !draw_row[11] && (32'(draw_row[10:0]) < SCREEN_HEIGHT);
		we       = (rows != '0) && (cfg.store_mode ? store_we : draw_we);
		row_end  = ({1'b0, col_q} + 11'd1) >= w_eff;
		last     = (rows != '0) && row_end && (({1'b0, row_q} + 10'd1) >= rows);
		part_r   = {pixel_byte, part_q[15:0]};

		phase_d   = phase_q;
		part_d    = part_q;
		col_d     = col_q;
		row_d     = row_q;
		pad_d     = pad_q;
		pad_act_d = pad_act_q;
		res_valid = 1'b0;

		res.argb         = {8'h00, part_r};
		res.column       = '0;
		res.row          = '0;
		res.to_store     = cfg.store_mode;
		res.write_enable = we;
		res.last_pixel   = last;
		if (we) begin
			res.column = cfg.store_mode ? col_q : draw_col[9:0];
			res.row    = cfg.store_mode ? base_row[8:0] : draw_row[8:0];
		end

		if (pad_act_q) begin
			pad_d     = pad_q - 2'd1;
			pad_act_d = (pad_d != '0);
		end else if (phase_q == 2'd3) begin
			res.argb  = {pixel_byte, part_q};
			res_valid = 1'b1;
		end else if (phase_q == 2'd2) begin
			part_d = part_r;
			if (cfg.depth_is_32) begin
				phase_d = 2'd3;
			end else begin
				res_valid = 1'b1;
			end
		end else if (phase_q == 2'd1) begin
			part_d  = {part_q[23:16], pixel_byte, part_q[7:0]};
			phase_d = 2'd2;
		end else begin
			part_d  = {part_q[23:8], pixel_byte};
			phase_d = 2'd1;
		end

		if (res_valid) begin
			phase_d = '0;
			part_d  = '0;
			if (row_end) begin
				col_d     = '0;
				row_d     = last ? 9'd0 : row_q + 9'd1;
				pad_d     = cfg.depth_is_32 ? 2'd0 : w_eff[1:0];
				pad_act_d = (pad_d != '0);
			end else begin
				col_d = col_q + 10'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= '0;
			part_q    <= '0;
			col_q     <= '0;
			row_q     <= '0;
			pad_q     <= '0;
			pad_act_q <= 1'b0;
		end else if (step) begin
			phase_q   <= phase_d;
			part_q    <= part_d;
			col_q     <= col_d;
			row_q     <= row_d;
			pad_q     <= pad_d;
			pad_act_q <= pad_act_d;
		end
	end

	`BMPU_ASSERT_NOW(a_pad_count_live, pad_act_q, pad_q != 2'd0)
	`BMPU_ASSERT_NEXT(a_last_rewinds, step && res_valid && last, (col_q == '0) && (row_q == '0))

endmodule

// ----- rtl/core/bmp_pixel_array_unpack.sv -----
// BMP pixel array unpacker: takes one pixel-array byte per transfer and gives
// one ARGB pixel with its destination per completed pixel (24 or 32 bpp),
// skipping row padding. A byte is accepted every cycle while the output can
// drain; a byte passes an input register and the decode logic, and its pixel
// is held in an output register until taken. Rate is set by the single decode
// step between those registers: one byte per cycle sustained while the output
// drains. Configuration writes are taken at any time and must only be issued
// while the block is idle. Depends on bmpu_pkg, bmpu_cfg_regs, bmpu_decode.
`include "bmp_pixel_array_unpack_assert.svh"

module bmp_pixel_array_unpack #(
	parameter int SCREEN_WIDTH  = 800,
	parameter int SCREEN_HEIGHT = 480
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [7:0] pixel_byte
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [55:0]                   m_tdata,   // [31:0] argb, [41:32] column,
	                                                 // [50:42] row, [55:51] zero
	output logic [1:0]                    m_tuser,   // [0] to_store, [1] write_enable
	output logic                          m_tlast,   // last_pixel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bmpu_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [bmpu_pkg::CfgDataW-1:0] cfg_data
);

	bmpu_pkg::cfg_t cfg;
	bmpu_pkg::res_t res;
	bmpu_pkg::res_t res_s2;
	logic           res_valid;
	logic           valid_s1;
	logic [7:0]     byte_s1;
	logic           out_valid_s2;
	logic           step;

	assign cfg_ready = 1'b1;

	bmpu_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	bmpu_decode #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.pixel_byte (byte_s1),
		.cfg        (cfg),
		.res_valid  (res_valid),
		.res        (res)
	);

	// A byte that completes no pixel may move on even while the output stalls.
	assign step     = valid_s1 && (!res_valid || !out_valid_s2 || m_tready);
	assign s_tready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			out_valid_s2 <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				valid_s1 <= 1'b1;
			end else if (step) begin
				valid_s1 <= 1'b0;
			end
			if (step && res_valid) begin
				out_valid_s2 <= 1'b1;
			end else if (m_tready) begin
				out_valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
		if (step && res_valid) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = out_valid_s2;
	assign m_tdata  = {5'b00000, res_s2.row, res_s2.column, res_s2.argb};
	assign m_tuser  = {res_s2.write_enable, res_s2.to_store};
	assign m_tlast  = res_s2.last_pixel;

	`BMPU_ASSERT_NOW(a_coords_zero_when_off, m_tvalid && !m_tuser[1], m_tdata[50:32] == '0)
	`BMPU_ASSERT_NEXT(a_result_lands, step && res_valid, m_tvalid)
	`BMPU_ASSERT_NOW(a_no_draw_top_down,
		m_tvalid && !m_tuser[0] && cfg.image_height[9], !m_tuser[1])

endmodule
